>>> src/twgfsr_pkg.sv
// Package of shared constants, types and functions for the twisted GFSR random generator.
package twgfsr_pkg;

	// Default number of words in the state store.
	localparam int STATE_WORDS_DEF = 624;

	// Offset of the tap word used while twisting.
	localparam int TAP_OFFSET = 367;

	// Twist and seeding constants. The upper mask is zero, so only the low
	// 31 bits of the following word take part in a twist.
	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] LOW_PART     = 32'h7fff_ffff;
	localparam logic [20:0] SEED_MULT    = 21'd1664525;
	localparam logic [30:0] SEED_RESET   = 31'd5389;

	// Tempering masks.
	localparam logic [31:0] TEMPER_B = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C = 32'hefc6_0000;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_TW_RD,
		ST_TW_WR,
		ST_RD,
		ST_LOAD
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic fill_step;
		logic twist_wr;
		logic sel_read;
		logic out_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seeded;
		logic exhausted;
		logic k_last;
		logic out_free;
	} dp_status_t;

	// Tempering of one word read from the store.
	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// One twist step: the tap word mixed with the low part of the next word.
	function automatic logic [31:0] twist_one(input logic [31:0] nxt, input logic [31:0] tap);
		logic [31:0] y;
		logic [31:0] v;
		y = nxt & LOW_PART;
		v = tap ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TWIST_MATRIX;
		end
		return v;
	endfunction

endpackage

>>> src/twgfsr_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module twgfsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> src/twgfsr_ctrl.sv
// Controller state machine sequencing seeding, twisting and word reads.
module twgfsr_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  twgfsr_pkg::dp_status_t  status,
	output twgfsr_pkg::ctrl_cmd_t   cmd,
	output twgfsr_pkg::ctrl_state_t state
);

	import twgfsr_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	assign state = state_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (!status.seeded) begin
						state_d = ST_FILL;
					end else if (status.exhausted) begin
						state_d = ST_TW_RD;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (status.k_last) begin
					state_d = ST_TW_RD;
				end
			end
			ST_TW_RD: begin
				state_d = ST_TW_WR;
			end
			ST_TW_WR: begin
				cmd.twist_wr = 1'b1;
				state_d = status.k_last ? ST_RD : ST_TW_RD;
			end
			ST_RD: begin
				cmd.sel_read = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// Hold the read address until the output register has room.
				cmd.sel_read = 1'b1;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/twgfsr_dp.sv
// Datapath: state store, seeding multiplier, twist unit, tempering and output register.
module twgfsr_dp #(
	parameter int STATE_WORDS = twgfsr_pkg::STATE_WORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [4:0]             shift_amount,
	input  logic                   seed_we,
	input  logic [30:0]            seed_wdata,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic [31:0]            random_value,
	input  twgfsr_pkg::ctrl_cmd_t  cmd,
	output twgfsr_pkg::dp_status_t status
);

	import twgfsr_pkg::*;

	localparam int AW = $clog2(STATE_WORDS);
	localparam int RW = $clog2(STATE_WORDS + 1);
	localparam logic [AW-1:0] K_LAST    = AW'(STATE_WORDS - 1);
	localparam logic [AW-1:0] TAP_START = AW'(TAP_OFFSET);
	localparam logic [RW-1:0] IDX_END   = RW'(STATE_WORDS);

	logic [30:0]   seed_q;
	logic          seeded_q;
	logic [RW-1:0] read_idx_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] tap_q;
	logic [30:0]   prev_q;
	logic [4:0]    shift_q;
	logic          out_valid_q;
	logic [31:0]   out_q;

	logic          k_last;
	logic          tap_last;
	logic [AW-1:0] k_next;
	logic [AW-1:0] tap_next;
	logic [30:0]   fill_next;
	logic [30:0]   fill_val;
	logic [31:0]   twist_val;
	logic          ram_we;
	logic [31:0]   ram_wdata;
	logic [AW-1:0] raddr_a;
	logic [31:0]   rdata_a;
	logic [31:0]   rdata_b;

	// Index arithmetic with wrap at the end of the store.
	assign k_last   = (k_q == K_LAST);
	assign tap_last = (tap_q == K_LAST);
	assign k_next   = k_last ? '0 : k_q + AW'(1);
	assign tap_next = tap_last ? '0 : tap_q + AW'(1);

	// Seeding recurrence: next = prev * multiplier + 1, kept to 31 bits.
	assign fill_next = 31'(prev_q * SEED_MULT) + 31'd1;
	assign fill_val  = (k_q == '0) ? seed_q : fill_next;

	// Twist of the current word from the next word and the tap word.
	assign twist_val = twist_one(rdata_a, rdata_b);

	// Store write and read port selection.
	assign ram_we    = cmd.fill_step | cmd.twist_wr;
	assign ram_wdata = cmd.fill_step ? {1'b0, fill_val} : twist_val;
	assign raddr_a   = cmd.sel_read ? read_idx_q[AW-1:0] : k_next;

	twgfsr_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (k_q),
		.wdata  (ram_wdata),
		.raddr_a(raddr_a),
		.raddr_b(tap_q),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// Seed register and seeded flag; a seed write forces a refill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= SEED_RESET;
			seeded_q <= 1'b0;
		end else if (seed_we) begin
			seed_q   <= seed_wdata;
			seeded_q <= 1'b0;
		end else if (cmd.fill_step && k_last) begin
			seeded_q <= 1'b1;
		end
	end

	// Sweep counters. Both return to their start values after a full sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			tap_q <= TAP_START;
		end else begin
			if (cmd.fill_step || cmd.twist_wr) begin
				k_q <= k_next;
			end
			if (cmd.twist_wr) begin
				tap_q <= tap_next;
			end
		end
	end

	// Read index: cleared by a twist, advanced by each delivered word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_idx_q <= '0;
		end else if (cmd.twist_wr && k_last) begin
			read_idx_q <= '0;
		end else if (cmd.out_load) begin
			read_idx_q <= read_idx_q + RW'(1);
		end
	end

	// Previous seeding value and captured shift amount.
	always_ff @(posedge clk) begin
		if (cmd.fill_step) begin
			prev_q <= fill_val;
		end
		if (cmd.accept) begin
			shift_q <= shift_amount;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload: tempered word shifted right.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= temper(rdata_a) >> shift_q;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign random_value = out_q;

	assign status.seeded    = seeded_q;
	assign status.exhausted = (read_idx_q == IDX_END);
	assign status.k_last    = k_last;
	assign status.out_free  = !out_valid_q || m_tready;

endmodule

>>> src/twisted_gfsr_random_generator.sv
// Top level of the twisted GFSR random generator.
//
// A request beat on the slave stream carries a shift amount in s_tdata[4:0];
// each request yields exactly one beat on the master stream holding the next
// tempered 32-bit word shifted right by that amount, in request order.
// The user writes the seed register through seed_we / seed_wdata only while
// idle; the block itself does not enforce this. A write marks the store unseeded,
// so the next request refills it. A request is taken only while the
// controller is idle, but a finished result may still be waiting in the
// output register at that time. An ordinary request passes through the
// read and load states, and m_tvalid rises as the load state ends; the
// next request is taken only once the controller is idle again. An
// exhausted store is first twisted: the single store is read and written
// in alternating states. An unseeded store is first filled before that twist.
// Reset clears the handshake state, loads the default seed 5389 and marks
// the store unseeded. The store itself needs no clearing pass.
// If the receiver stalls, the result is held in the output register and the
// next request stops once its own word is ready to load.
module twisted_gfsr_random_generator #(
	parameter int STATE_WORDS = twgfsr_pkg::STATE_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [4:0] shift_amount, [7:5] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] random_value
	input  logic        seed_we,
	input  logic [30:0] seed_wdata
);

	import twgfsr_pkg::*;

	ctrl_cmd_t   cmd;
	dp_status_t  status;
	ctrl_state_t state;

	// Controller.
	twgfsr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd),
		.state   (state)
	);

	// Datapath.
	twgfsr_dp #(
		.STATE_WORDS(STATE_WORDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.shift_amount(s_tdata[4:0]),
		.seed_we     (seed_we),
		.seed_wdata  (seed_wdata),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.random_value(m_tdata),
		.cmd         (cmd),
		.status      (status)
	);

`ifndef SYNTHESIS
	// A new result only appears from the load state.
	a_rise_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state) == ST_LOAD)
		else $error("result appeared outside the load state");

	// A seed write always forces a refill.
	a_seed_unseeds: assert property (@(posedge clk) disable iff (!arst_n)
		seed_we |=> !status.seeded)
		else $error("store still marked seeded after a seed write");

	// Reads happen only from a seeded store that still holds unread words.
	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state == ST_RD |-> status.seeded && !status.exhausted)
		else $error("word read from an unseeded or exhausted store");

	// A stalled result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !cmd.out_load)
		else $error("output register loaded while a beat was stalled");
`endif

endmodule
